// ===== rtl/assert_macros.svh =====
// Assertion helpers for the smoother block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// A property checked at every rising edge while reset is released.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// A property checked at every rising edge, during reset too.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/m3s_pkg.sv =====
package m3s_pkg;

	// Samples seen so far in the current sequence, saturating at the running state.
	typedef enum logic [1:0] {
		POS_FIRST,
		POS_SECOND,
		POS_THIRD,
		POS_RUN
	} pos_t;

	// Result queue sizing: a final sample can push three results at once.
	localparam int QUEUE_DEPTH = 4;
	localparam int MAX_PUSH    = 3;

	// Results produced by one accepted transaction.
	typedef struct packed {
		logic [1:0] count;     // number of result slots written, 0 to MAX_PUSH
		logic       mark_last; // the last written slot closes the sequence
	} push_ctl_t;

endpackage

// ===== rtl/median3_then_binomial_smoother_top.sv =====
// Median-of-three filter followed by a 1-2-1 smoother over sequences of
// unsigned Q16.8 frame-time samples, the last one flagged by final_sample.
// A sample transaction is taken in every cycle while the four-entry result
// queue has room for three results; each result is registered in that queue
// before it can be taken. The first result of a sequence is its first
// sample, each later sample from the fourth on yields the smoothed value two
// places back, and the final sample pushes the remaining one to three results
// with final_result set on the last. Draining that tail through the single
// output port is what holds the input back at the end of a sequence when the
// output side takes a result every cycle. The window is two shift cells of raw
// and median taps.
`include "assert_macros.svh"

module median3_then_binomial_smoother_top import m3s_pkg::*; #(
	parameter int SAMPLE_WIDTH = 24
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    sample_valid,
	output logic                    sample_ready,
	input  logic [SAMPLE_WIDTH-1:0] sample,
	input  logic                    final_sample,
	output logic                    result_valid,
	input  logic                    result_ready,
	output logic [SAMPLE_WIDTH-1:0] smoothed,
	output logic                    final_result
);

	localparam int W = SAMPLE_WIDTH;

	pos_t         pos_q;
	pos_t         pos_d;
	logic         accept;
	logic [W-1:0] raw0;
	logic [W-1:0] raw1;
	logic [W-1:0] med0;
	logic [W-1:0] med1;
	logic [W-1:0] med0_in;
	logic [W-1:0] lo01;
	logic [W-1:0] hi01;
	logic [W-1:0] mid;
	logic [W-1:0] slot [MAX_PUSH];
	push_ctl_t    push;

	function automatic logic [W-1:0] blend121(input logic [W-1:0] a, input logic [W-1:0] b,
			input logic [W-1:0] c);
		logic [W+1:0] sum;
		sum = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
		return sum[W+1:2];
	endfunction

	assign accept = sample_valid && sample_ready;

	// Median of the two stored raw samples and the new one.
	assign lo01 = (raw0 < raw1) ? raw0 : raw1;
	assign hi01 = (raw0 < raw1) ? raw1 : raw0;
	assign mid  = (hi01 < sample) ? hi01 : ((lo01 > sample) ? lo01 : sample);

	// On the third sample the older median tap takes the first raw sample,
	// which stands in for the median at the start of the sequence.
	assign med0_in = (pos_q == POS_THIRD) ? raw0 : med1;

	m3s_cell #(.W(W)) u_cell_new (
		.clk    (clk),
		.en     (accept),
		.raw_in (sample),
		.med_in (mid),
		.raw_q  (raw1),
		.med_q  (med1)
	);

	m3s_cell #(.W(W)) u_cell_old (
		.clk    (clk),
		.en     (accept),
		.raw_in (raw1),
		.med_in (med0_in),
		.raw_q  (raw0),
		.med_q  (med0)
	);

	always_comb begin
		pos_d = pos_q;
		if (accept) begin
			if (final_sample) begin
				pos_d = POS_FIRST;
			end else begin
				unique case (pos_q)
					POS_FIRST:  pos_d = POS_SECOND;
					POS_SECOND: pos_d = POS_THIRD;
					POS_THIRD:  pos_d = POS_RUN;
					POS_RUN:    pos_d = POS_RUN;
					default:    pos_d = POS_FIRST;
				endcase
			end
		end
	end

	always_comb begin
		slot[0]        = sample;
		slot[1]        = sample;
		slot[2]        = sample;
		push.count     = 2'd0;
		push.mark_last = final_sample;
		unique case (pos_q)
			POS_FIRST: begin
				push.count = 2'd1;
			end
			POS_SECOND: begin
				push.count = final_sample ? 2'd1 : 2'd0;
			end
			POS_THIRD: begin
				slot[0]    = blend121(raw0, mid, sample);
				push.count = final_sample ? 2'd2 : 2'd0;
			end
			POS_RUN: begin
				slot[0]    = blend121(med0, med1, mid);
				slot[1]    = blend121(med1, mid, sample);
				push.count = final_sample ? 2'd3 : 2'd1;
			end
			default: begin
				push.count = 2'd0;
			end
		endcase
		if (!accept) begin
			push.count = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_FIRST;
		end else begin
			pos_q <= pos_d;
		end
	end

	m3s_outq #(.W(W)) u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.slot      (slot),
		.room      (sample_ready),
		.out_valid (result_valid),
		.out_ready (result_ready),
		.out_value (smoothed),
		.out_last  (final_result)
	);

	`ASSERT_RST(a_final_restarts, clk, arst_n, accept && final_sample |=> pos_q == POS_FIRST, "final sample did not restart the sequence")
	`ASSERT_RST(a_first_emits, clk, arst_n, accept && pos_q == POS_FIRST |=> result_valid, "first sample of a sequence produced no result")
	`ASSERT_ALWAYS(a_full_has_data, clk, !sample_ready |-> result_valid, "input held back while the result queue is empty")

endmodule

// ===== rtl/m3s_cell.sv =====
module m3s_cell import m3s_pkg::*; #(
	parameter int W = 24
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] raw_in,
	input  logic [W-1:0] med_in,
	output logic [W-1:0] raw_q,
	output logic [W-1:0] med_q
);

	// One tap of the window: a raw sample and a median value, shifted on enable.
	always_ff @(posedge clk) begin
		if (en) begin
			raw_q <= raw_in;
			med_q <= med_in;
		end
	end

endmodule

// ===== rtl/m3s_outq.sv =====
module m3s_outq import m3s_pkg::*; #(
	parameter int W = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	input  push_ctl_t    push,
	input  logic [W-1:0] slot [MAX_PUSH],
	output logic         room,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] out_value,
	output logic         out_last
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [W-1:0]     val_q [QUEUE_DEPTH];
	logic [W-1:0]     val_d [QUEUE_DEPTH];
	logic             fin_q [QUEUE_DEPTH];
	logic             fin_d [QUEUE_DEPTH];
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_d;
	logic [CNT_W-1:0] base;
	logic             pop;

	assign pop  = (cnt_q != '0) && out_ready;
	assign base = cnt_q - CNT_W'(pop);
	assign cnt_d = base + CNT_W'(push.count);

	// The head sits at entry zero; a pop shifts the queue down by one and new
	// results land just above the surviving entries.
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			val_d[i] = val_q[i];
			fin_d[i] = fin_q[i];
		end
		if (pop) begin
			for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
				val_d[i] = val_q[i+1];
				fin_d[i] = fin_q[i+1];
			end
		end
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			for (int j = 0; j < MAX_PUSH; j++) begin
				if ((2'(j) < push.count) && (base + CNT_W'(j) == CNT_W'(i))) begin
					val_d[i] = slot[j];
					fin_d[i] = push.mark_last && (2'(j) + 2'd1 == push.count);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			val_q[i] <= val_d[i];
			fin_q[i] <= fin_d[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	assign room      = cnt_q <= CNT_W'(QUEUE_DEPTH - MAX_PUSH);
	assign out_valid = cnt_q != '0;
	assign out_value = val_q[0];
	assign out_last  = fin_q[0];

endmodule

// ===== test/median3_then_binomial_smoother_top_test.sv =====
`timescale 1ns / 100ps

// Predicts the smoothed stream and checks it against what the block delivers.
class smoother_scoreboard #(int SW = 24);
	localparam int PENDING_SLOTS = 64;

	logic [SW-1:0] raw_tap[2];
	logic [SW-1:0] median_tap[2];
	m3s_pkg::pos_t position;
	// Expected results wait in a small ring until the block delivers them.
	logic [SW-1:0] pending_value[PENDING_SLOTS];
	bit pending_last[PENDING_SLOTS];
	int pending_head;
	int pending_tail;
	int pending_count;
	int errors;
	int checked;
	int samples;
	int sequences;

	function new();
		errors = 0;
		checked = 0;
		samples = 0;
		sequences = 0;
		pending_head = 0;
		pending_tail = 0;
		pending_count = 0;
		clear_window();
	endfunction

	function void clear_window();
		raw_tap[0] = '0;
		raw_tap[1] = '0;
		median_tap[0] = '0;
		median_tap[1] = '0;
		position = m3s_pkg::POS_FIRST;
	endfunction

	// The middle value is the total less the smallest and the largest.
	function logic [SW-1:0] middle_of(logic [SW-1:0] a, logic [SW-1:0] b, logic [SW-1:0] c);
		logic [SW+1:0] total;
		logic [SW-1:0] lo;
		logic [SW-1:0] hi;
		lo = (a < b) ? a : b;
		lo = (lo < c) ? lo : c;
		hi = (a > b) ? a : b;
		hi = (hi > c) ? hi : c;
		total = {2'b0, a} + {2'b0, b} + {2'b0, c} - {2'b0, lo} - {2'b0, hi};
		return total[SW-1:0];
	endfunction

	function logic [SW-1:0] blend(logic [SW-1:0] a, logic [SW-1:0] b, logic [SW-1:0] c);
		logic [SW+1:0] total;
		total = {2'b0, a} + {1'b0, b, 1'b0} + {2'b0, c};
		return total[SW+1:2];
	endfunction

	function void push(logic [SW-1:0] value, bit last);
		pending_value[pending_tail] = value;
		pending_last[pending_tail] = last;
		pending_tail = (pending_tail + 1) % PENDING_SLOTS;
		pending_count++;
	endfunction

	function void note_sample(logic [SW-1:0] x, bit fin);
		logic [SW-1:0] mid;
		samples++;
		case (position)
			m3s_pkg::POS_FIRST: begin
				push(x, fin);
				raw_tap[1] = x;
				position = m3s_pkg::POS_SECOND;
			end
			m3s_pkg::POS_SECOND: begin
				if (fin)
					push(x, 1'b1);
				raw_tap[0] = raw_tap[1];
				raw_tap[1] = x;
				position = m3s_pkg::POS_THIRD;
			end
			m3s_pkg::POS_THIRD: begin
				mid = middle_of(raw_tap[0], raw_tap[1], x);
				median_tap[0] = raw_tap[0];
				median_tap[1] = mid;
				if (fin) begin
					push(blend(raw_tap[0], mid, x), 1'b0);
					push(x, 1'b1);
				end
				raw_tap[0] = raw_tap[1];
				raw_tap[1] = x;
				position = m3s_pkg::POS_RUN;
			end
			default: begin
				mid = middle_of(raw_tap[0], raw_tap[1], x);
				push(blend(median_tap[0], median_tap[1], mid), 1'b0);
				if (fin) begin
					push(blend(median_tap[1], mid, x), 1'b0);
					push(x, 1'b1);
				end
				median_tap[0] = median_tap[1];
				median_tap[1] = mid;
				raw_tap[0] = raw_tap[1];
				raw_tap[1] = x;
			end
		endcase
		if (fin) begin
			sequences++;
			clear_window();
		end
	endfunction

	function void check_result(logic [SW-1:0] value, logic last);
		logic [SW-1:0] want_value;
		bit want_last;
		if (pending_count == 0) begin
			errors++;
			$display("%0t: result transaction with nothing expected: smoothed %h final_result %b",
				$time, value, last);
			return;
		end
		want_value = pending_value[pending_head];
		want_last = pending_last[pending_head];
		pending_head = (pending_head + 1) % PENDING_SLOTS;
		pending_count--;
		checked++;
		if (value !== want_value) begin
			errors++;
			$display("%0t: smoothed mismatch: expected %h actual %h", $time, want_value, value);
		end
		if (last !== want_last) begin
			errors++;
			$display("%0t: final_result mismatch: expected %b actual %b", $time, want_last, last);
		end
	endfunction

	function int outstanding();
		return pending_count;
	endfunction
endclass

module median3_then_binomial_smoother_top_test;
	localparam int SW = 24;
	localparam logic [SW-1:0] TOP = {SW{1'b1}};
	localparam int RANDOM_SAMPLES = 400;
	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic sample_valid;
	logic sample_ready;
	logic [SW-1:0] sample;
	logic final_sample;
	logic result_valid;
	logic result_ready;
	logic [SW-1:0] smoothed;
	logic final_result;

	smoother_scoreboard #(SW) sb;
	int cycle_count = 0;
	int tx_gap_pct;
	int rx_stall_pct;
	int random_sent;

	median3_then_binomial_smoother_top #(.SAMPLE_WIDTH(SW)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample(sample),
		.final_sample(final_sample),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.smoothed(smoothed),
		.final_result(final_result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			sb.check_result(smoothed, final_result);
	end

	// Output side: ready drops in bursts whose frequency the main flow sets.
	initial begin : result_side
		int stall_left;
		stall_left = 0;
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0 && rx_stall_pct != 0) begin
				result_ready <= 1'b0;
				stall_left--;
			end else begin
				stall_left = 0;
				result_ready <= 1'b1;
				if ($urandom_range(99, 0) < rx_stall_pct)
					stall_left = $urandom_range(19, 1);
			end
		end
	end

	task automatic send_sample(input logic [SW-1:0] x, input bit fin);
		@(negedge clk);
		sample_valid <= 1'b1;
		sample <= x;
		final_sample <= fin;
		do
			@(posedge clk);
		while (!sample_ready);
		sb.note_sample(x, fin);
		if ($urandom_range(99, 0) < tx_gap_pct)
			repeat ($urandom_range(19, 1)) begin
				@(negedge clk);
				sample_valid <= 1'b0;
			end
	endtask

	task automatic wait_for_drain();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
	endtask

	function automatic logic [SW-1:0] pick_value(int style, logic [SW-1:0] base);
		case (style)
			0: return SW'($urandom());
			1: return SW'($urandom_range(255, 0));
			2: return TOP - SW'($urandom_range(255, 0));
			3: return ($urandom_range(7, 0) == 0) ? SW'($urandom()) :
				SW'(base + $urandom_range(15, 0));
			default: return $urandom_range(1, 0) ? TOP : '0;
		endcase
	endfunction

	task automatic send_sequence(input int len, input int style);
		logic [SW-1:0] base;
		base = SW'($urandom());
		for (int i = 0; i < len; i++) begin
			send_sample(pick_value(style, base), i == len - 1);
			random_sent++;
		end
	endtask

	task automatic send_directed();
		send_sample('0, 1'b1);
		send_sample(TOP, 1'b1);
		send_sample(TOP, 1'b0);
		send_sample('0, 1'b1);
		repeat (2) send_sample(TOP, 1'b0);
		send_sample(TOP, 1'b1);
		send_sample('0, 1'b0);
		send_sample(TOP, 1'b0);
		send_sample('0, 1'b1);
		for (int i = 0; i < 4; i++)
			send_sample(i[0] ? '0 : TOP, i == 3);
		// Rising and falling ramps with odd low bits exercise the truncation.
		for (int i = 0; i < 5; i++)
			send_sample(SW'(3 * i + 1), i == 4);
		for (int i = 0; i < 5; i++)
			send_sample(TOP - SW'(5 * i), i == 4);
	endtask

	initial begin : stimulus
		int len;
		bit drained;
		sb = new();
		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample = '0;
		final_sample = 1'b0;
		tx_gap_pct = 0;
		rx_stall_pct = 0;
		random_sent = 0;
		drained = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_directed();
		tx_gap_pct = 20;
		rx_stall_pct = 10;
		send_directed();
		wait_for_drain();

		while (random_sent < RANDOM_SAMPLES) begin
			if (random_sent >= RANDOM_SAMPLES - 60) begin
				tx_gap_pct = 0;
				rx_stall_pct = 0;
			end else begin
				// Stretches with no idling are mixed at random with busy ones on either side.
				tx_gap_pct = $urandom_range(2, 0) == 0 ? 0 : $urandom_range(30, 2);
				rx_stall_pct = $urandom_range(2, 0) == 0 ? 0 : $urandom_range(30, 2);
			end
			case ($urandom_range(9, 0))
				0, 1: len = $urandom_range(4, 1);
				2: len = $urandom_range(40, 13);
				default: len = $urandom_range(12, 1);
			endcase
			send_sequence(len, $urandom_range(4, 0));
			if (!drained && random_sent >= RANDOM_SAMPLES / 2) begin
				drained = 1;
				wait_for_drain();
			end
		end

		@(negedge clk);
		sample_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d samples in %0d sequences; checked %0d smoothed results, %0d errors.",
			sb.samples, sb.sequences, sb.checked, sb.errors);
		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/m3s_pkg.sv
rtl/m3s_cell.sv
rtl/m3s_outq.sv
rtl/median3_then_binomial_smoother_top.sv
test/median3_then_binomial_smoother_top_test.sv
